/* rtl/core/fsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the FASTA symbol stream packer.
// Command and result codes, the configuration bundle and the item structs.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Bytes with a special meaning in a FASTA file.
  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  // Largest number of padding symbols at one record boundary.
  localparam logic [5:0] MAX_PAD = 6'd63;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TERM_SYMBOL   = 2'd0;
  localparam logic [1:0] CFG_PAD_COUNT     = 2'd1;
  localparam logic [1:0] CFG_BUFFER_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_BYTE     = 2'd1,
    CMD_EOF      = 2'd2,
    CMD_NEW_FILE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SYMBOL    = 3'd0,
    KIND_PAD       = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_NO_RECORD = 3'd3,
    KIND_HDR_EOF   = 3'd4,
    KIND_OVERFLOW  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0]  term_symbol;
    logic [5:0]  pad_count;
    logic [31:0] buffer_length;
  } cfg_t;

  // One accepted input item as the engine sees it.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] byte_value;
    logic       in_range;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  symbol;
    logic [31:0] position;
    logic [31:0] record_count;
    logic        last;
  } res_t;

endpackage

/* rtl/core/fasta_symbol_stream_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_symbol_stream_packer: packs the sequence letters of a FASTA file.
// An item is registered at acceptance; its first result is registered after.
// Throughput: one item per cycle while each item gives at most one result and
// the receiver does not stall; a padding burst holds the input until done.
// Reset clears parse state, configuration and handshake state at once; the
// translation table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module fasta_symbol_stream_packer
  import fsp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port.
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  // Input item channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        byte_value_i,
  input  logic signed [7:0] table_value_i,
  // Result item channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        kind_o,
  output logic [7:0]        symbol_o,
  output logic [31:0]       position_o,
  output logic [31:0]       record_count_o,
  output logic              last_o
);

  localparam int         AddrW      = $clog2(TABLE_ENTRIES);
  localparam logic [8:0] TableLimit = 9'(TABLE_ENTRIES);

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.term_symbol   <= 8'd0;
      cfg_q.pad_count     <= 6'd0;
      cfg_q.buffer_length <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TERM_SYMBOL:   cfg_q.term_symbol   <= cfg_data_i[7:0];
        CFG_PAD_COUNT:     cfg_q.pad_count     <= cfg_data_i[5:0];
        CFG_BUFFER_LENGTH: cfg_q.buffer_length <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register. The table is read at acceptance so that the entry
  // arrives together with the item; loads write the table at acceptance, so
  // any later byte sees them.
  logic       accept;
  logic       in_range;
  logic       item_done;
  logic       s1_valid_q;
  item_t      s1_item_q;
  logic [7:0] entry;

  assign in_range   = ({1'b0, byte_value_i} < TableLimit);
  assign in_stall_o = s1_valid_q && !item_done;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (item_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.cmd        <= cmd_e'(command_i);
      s1_item_q.byte_value <= byte_value_i;
      s1_item_q.in_range   <= in_range;
    end
  end

  fsp_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (accept && (cmd_e'(command_i) == CMD_LOAD) && in_range),
    .waddr_i(byte_value_i[AddrW-1:0]),
    .wdata_i($unsigned(table_value_i)),
    .re_i   (accept),
    .raddr_i(byte_value_i[AddrW-1:0]),
    .rdata_o(entry)
  );

  // Parse engine: at most one result per cycle into the output register, unless the receiver stalls.
  logic out_valid_q;
  logic out_ready;
  logic emit;
  res_t res;
  res_t out_q;

  assign out_ready = !out_valid_q || !out_stall_i;

  fsp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(s1_valid_q),
    .item_i      (s1_item_q),
    .entry_i     (entry),
    .out_ready_i (out_ready),
    .emit_o      (emit),
    .res_o       (res),
    .item_done_o (item_done)
  );

  // Output register: holds a result while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign symbol_o       = out_q.symbol;
  assign position_o     = out_q.position;
  assign record_count_o = out_q.record_count;
  assign last_o         = out_q.last;

endmodule

/* rtl/core/fsp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_ram: generic single write port RAM with a registered read port.
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/fsp_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_engine: parse state and result sequencing.
// Produces at most one result per cycle while out_ready_i is high, for the item in the input register.
// ----------------------------------------------------------------------------
module fsp_engine
  import fsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_valid_i,
  input  item_t      item_i,
  input  logic [7:0] entry_i,
  input  logic       out_ready_i,
  output logic       emit_o,
  output res_t       res_o,
  output logic       item_done_o
);

  typedef enum logic [1:0] {
    MODE_SEEK   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_SEQ    = 2'd2,
    MODE_HALT   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_PAD   = 2'd1,
    PH_OVF   = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic        prev_nl_q, prev_nl_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] records_q, records_d;
  logic [5:0]  left_q, left_d;

  logic [5:0]  pads;
  logic [5:0]  left_now;
  logic [31:0] off_inc;
  logic        ovf;
  logic        is_gt;
  logic        is_nl;
  logic        pad_step;

  assign pads     = (cfg_i.pad_count > MAX_PAD) ? MAX_PAD : cfg_i.pad_count;
  assign left_now = (phase_q == PH_PAD) ? left_q : pads;
  assign off_inc  = offset_q + 32'd1;
  assign ovf      = (off_inc >= cfg_i.buffer_length);
  assign is_gt    = (item_i.byte_value == CHAR_GT);
  assign is_nl    = (item_i.byte_value == CHAR_NL);

  always_comb begin
    mode_d       = mode_q;
    phase_d      = phase_q;
    prev_nl_d    = prev_nl_q;
    offset_d     = offset_q;
    records_d    = records_q;
    left_d       = left_q;
    emit_o       = 1'b0;
    item_done_o  = 1'b0;
    pad_step     = 1'b0;
    res_o.kind         = KIND_SYMBOL;
    res_o.symbol       = 8'd0;
    res_o.position     = offset_q;
    res_o.record_count = records_q;
    res_o.last         = 1'b0;

    if (item_valid_i) begin
      case (phase_q)
        PH_START: begin
          case (item_i.cmd)
            CMD_LOAD: begin
              item_done_o = 1'b1;
            end
            CMD_NEW_FILE: begin
              mode_d      = MODE_SEEK;
              prev_nl_d   = 1'b0;
              offset_d    = 32'd0;
              records_d   = 32'd0;
              item_done_o = 1'b1;
            end
            CMD_BYTE: begin
              case (mode_q)
                MODE_SEEK: begin
                  if (!is_gt) begin
                    item_done_o = 1'b1;
                  end else if (pads == 6'd0) begin
                    mode_d      = MODE_HEADER;
                    item_done_o = 1'b1;
                  end else if (out_ready_i) begin
                    pad_step = 1'b1;
                  end
                end
                MODE_HEADER: begin
                  if (is_nl) begin
                    records_d = records_q + 32'd1;
                    prev_nl_d = 1'b0;
                    mode_d    = MODE_SEQ;
                  end
                  item_done_o = 1'b1;
                end
                MODE_SEQ: begin
                  if (is_gt && prev_nl_q) begin
                    if (pads == 6'd0) begin
                      mode_d      = MODE_HEADER;
                      prev_nl_d   = 1'b0;
                      item_done_o = 1'b1;
                    end else if (out_ready_i) begin
                      pad_step = 1'b1;
                    end
                  end else if (item_i.in_range && !entry_i[7]) begin
                    if (out_ready_i) begin
                      emit_o       = 1'b1;
                      res_o.kind   = KIND_SYMBOL;
                      res_o.symbol = entry_i;
                      offset_d     = off_inc;
                      if (ovf) begin
                        phase_d = PH_OVF;
                      end else begin
                        res_o.last  = 1'b1;
                        prev_nl_d   = is_nl;
                        item_done_o = 1'b1;
                      end
                    end
                  end else begin
                    // Dropped byte: no result, but it still counts as the
                    // previous byte for record boundary detection.
                    prev_nl_d   = is_nl;
                    item_done_o = 1'b1;
                  end
                end
                default: begin
                  item_done_o = 1'b1;
                end
              endcase
            end
            default: begin
              // End of file.
              case (mode_q)
                MODE_SEEK: begin
                  if (out_ready_i) begin
                    emit_o      = 1'b1;
                    res_o.kind  = KIND_NO_RECORD;
                    res_o.last  = 1'b1;
                    mode_d      = MODE_HALT;
                    item_done_o = 1'b1;
                  end
                end
                MODE_HEADER: begin
                  if (out_ready_i) begin
                    emit_o      = 1'b1;
                    res_o.kind  = KIND_HDR_EOF;
                    res_o.last  = 1'b1;
                    mode_d      = MODE_HALT;
                    item_done_o = 1'b1;
                  end
                end
                MODE_SEQ: begin
                  if (out_ready_i) begin
                    if (offset_q != 32'd0 && pads != 6'd0) begin
                      pad_step = 1'b1;
                    end else begin
                      emit_o      = 1'b1;
                      res_o.kind  = KIND_DONE;
                      res_o.last  = 1'b1;
                      mode_d      = MODE_HALT;
                      item_done_o = 1'b1;
                    end
                  end
                end
                default: begin
                  item_done_o = 1'b1;
                end
              endcase
            end
          endcase
        end
        PH_PAD: begin
          if (out_ready_i) begin
            pad_step = 1'b1;
          end
        end
        PH_OVF: begin
          if (out_ready_i) begin
            emit_o      = 1'b1;
            res_o.kind  = KIND_OVERFLOW;
            res_o.last  = 1'b1;
            mode_d      = MODE_HALT;
            phase_d     = PH_START;
            item_done_o = 1'b1;
          end
        end
        default: begin
          if (out_ready_i) begin
            emit_o      = 1'b1;
            res_o.kind  = KIND_DONE;
            res_o.last  = 1'b1;
            mode_d      = MODE_HALT;
            phase_d     = PH_START;
            item_done_o = 1'b1;
          end
        end
      endcase

      // One padding symbol of a burst. Only padding written in sequence
      // mode is checked against the buffer length.
      if (pad_step) begin
        emit_o       = 1'b1;
        res_o.kind   = KIND_PAD;
        res_o.symbol = cfg_i.term_symbol;
        offset_d     = off_inc;
        if (mode_q == MODE_SEQ && ovf) begin
          phase_d = PH_OVF;
        end else if (left_now == 6'd1) begin
          if (item_i.cmd == CMD_EOF) begin
            phase_d = PH_DONE;
          end else begin
            res_o.last  = 1'b1;
            mode_d      = MODE_HEADER;
            prev_nl_d   = 1'b0;
            phase_d     = PH_START;
            item_done_o = 1'b1;
          end
        end else begin
          phase_d = PH_PAD;
          left_d  = left_now - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SEEK;
      phase_q   <= PH_START;
      prev_nl_q <= 1'b0;
      offset_q  <= 32'd0;
      records_q <= 32'd0;
      left_q    <= 6'd0;
    end else begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      prev_nl_q <= prev_nl_d;
      offset_q  <= offset_d;
      records_q <= records_d;
      left_q    <= left_d;
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the FASTA symbol stream packer.
// File bytes, table loads, end-of-file and new-file items are streamed in
// with random gaps while the result side stalls at random. A behavioral
// packer inside the bench predicts every written symbol, padding run and
// status result, and each accepted result is compared with the oldest one.
// ----------------------------------------------------------------------------
module tb
  import fsp_pkg::*;
();

  // Cycles without any handshake before the run is declared hung. The worst
  // correct stretch is a long receiver stall or sender gap, or the short settle
  // time around a register write.
  localparam int unsigned STALL_LIMIT = 2000;

  // Rough total of input items, directed ones included, that the random part aims for.
  localparam int unsigned ITEM_GOAL = 410;

  // Parse states of the bench's own packer.
  typedef enum logic [1:0] {
    PM_SEEK,
    PM_HEADER,
    PM_SEQ,
    PM_HALT
  } parse_mode_e;

  // One input item as it waits in the send queue.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] byte_value;
    logic [7:0] table_value;
  } file_item_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_index_i = CFG_TERM_SYMBOL;
  logic [31:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        command_i = CMD_LOAD;
  logic [7:0]        byte_value_i = '0;
  logic signed [7:0] table_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        kind_o;
  logic [7:0]        symbol_o;
  logic [31:0]       position_o;
  logic [31:0]       record_count_o;
  logic              last_o;

  fasta_symbol_stream_packer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .byte_value_i   (byte_value_i),
    .table_value_i  (table_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .symbol_o       (symbol_o),
    .position_o     (position_o),
    .record_count_o (record_count_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Items waiting to be sent and results waiting to be seen.
  file_item_t  file_items[$];
  res_t        awaited_writes[$];

  // Register copies and parse state of the bench's packer.
  logic [7:0]  term_sh = 8'd0;
  logic [5:0]  pad_sh = 6'd0;
  logic [31:0] cap_sh = 32'hFFFF_FFFF;
  parse_mode_e pmode = PM_SEEK;
  logic        after_nl = 1'b0;
  logic [31:0] wr_off = '0;
  logic [31:0] rec_seen = '0;
  logic [7:0]  xlat [256];

  // The generator only ever sends a file byte whose table entry it has
  // loaded before, so a never-written entry is never looked up.
  bit          entry_loaded [256];

  int unsigned items_queued = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_gap = 0;
  int unsigned recv_calm = 0;
  int unsigned quiet_cycles = 0;
  file_item_t  next_item;
  res_t        got;
  res_t        want;

  // --------------------------------------------------------------------------
  // Behavioral packer. Every result is stamped with the record count at the
  // time it is written; the last result of an item gets its last flag once
  // the item has been worked through.
  // --------------------------------------------------------------------------
  function automatic void emit(kind_e kind, logic [7:0] sym, logic [31:0] pos);
    res_t r;
    r.kind = kind;
    r.symbol = sym;
    r.position = pos;
    r.record_count = rec_seen;
    r.last = 1'b0;
    awaited_writes.push_back(r);
  endfunction

  // A write that counts against the buffer. Reaching the capacity reports
  // the symbol that filled it, then the overflow, and halts the parser.
  function automatic bit put_symbol(kind_e kind, logic [7:0] sym);
    emit(kind, sym, wr_off);
    wr_off = wr_off + 32'd1;
    if (wr_off >= cap_sh) begin
      emit(KIND_OVERFLOW, 8'd0, wr_off);
      pmode = PM_HALT;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit put_padding();
    int i;
    for (i = 0; i < int'(pad_sh); i++) begin
      if (!put_symbol(KIND_PAD, term_sh)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void pack_step(cmd_e cmd, logic [7:0] b, logic [7:0] tv);
    int unsigned before_n;
    int          i;
    logic [7:0]  entry;
    bit          ok;
    res_t        tail;
    before_n = awaited_writes.size();
    case (cmd)
      CMD_LOAD: begin
        xlat[b] = tv;
      end
      CMD_NEW_FILE: begin
        // Table and registers survive a new file.
        pmode = PM_SEEK;
        after_nl = 1'b0;
        wr_off = '0;
        rec_seen = '0;
      end
      CMD_BYTE: begin
        case (pmode)
          PM_SEEK: begin
            // The opening padding is never checked against the capacity.
            if (b == CHAR_GT) begin
              for (i = 0; i < int'(pad_sh); i++) begin
                emit(KIND_PAD, term_sh, wr_off);
                wr_off = wr_off + 32'd1;
              end
              pmode = PM_HEADER;
            end
          end
          PM_HEADER: begin
            // The record counts once its header line ends; the byte right
            // after the header never acts as a preceding newline.
            if (b == CHAR_NL) begin
              rec_seen = rec_seen + 32'd1;
              after_nl = 1'b0;
              pmode = PM_SEQ;
            end
          end
          PM_SEQ: begin
            if (b == CHAR_GT && after_nl) begin
              if (put_padding()) begin
                pmode = PM_HEADER;
                after_nl = 1'b0;
              end
            end else begin
              // A negative table entry drops the byte.
              entry = xlat[b];
              ok = 1'b1;
              if (!entry[7]) ok = put_symbol(KIND_SYMBOL, entry);
              if (ok) after_nl = (b == CHAR_NL);
            end
          end
          default: ;
        endcase
      end
      default: begin
        // End of file.
        case (pmode)
          PM_SEEK: begin
            emit(KIND_NO_RECORD, 8'd0, wr_off);
            pmode = PM_HALT;
          end
          PM_HEADER: begin
            emit(KIND_HDR_EOF, 8'd0, wr_off);
            pmode = PM_HALT;
          end
          PM_SEQ: begin
            ok = 1'b1;
            if (wr_off != 0) ok = put_padding();
            if (ok) begin
              emit(KIND_DONE, 8'd0, wr_off);
              pmode = PM_HALT;
            end
          end
          default: ;
        endcase
      end
    endcase
    if (awaited_writes.size() > before_n) begin
      tail = awaited_writes.pop_back();
      tail.last = 1'b1;
      awaited_writes.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_item(cmd_e cmd, logic [7:0] b, logic [7:0] tv);
    file_item_t it;
    it.cmd = cmd;
    it.byte_value = b;
    it.table_value = tv;
    file_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_load(logic [7:0] idx, logic [7:0] tv);
    queue_item(CMD_LOAD, idx, tv);
    entry_loaded[idx] = 1'b1;
  endtask

  // A file byte, preceded by a load of its table entry if it has none yet.
  // Most fresh entries are symbols; about one in five drops the byte.
  task automatic queue_byte(logic [7:0] b);
    if (!entry_loaded[b]) begin
      if ($urandom_range(4) == 0) queue_load(b, 8'($urandom_range(255, 128)));
      else queue_load(b, 8'($urandom_range(127)));
    end
    queue_item(CMD_BYTE, b, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_byte(logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == avoid) b = ~avoid;
    return b;
  endfunction

  // Mostly nucleotide letters, now and then any byte at all.
  function automatic logic [7:0] seq_letter();
    string alphabet;
    alphabet = "ACGTNacgtnRY";
    if ($urandom_range(9) == 0) return 8'($urandom);
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  task automatic queue_record();
    queue_byte(CHAR_GT);
    repeat ($urandom_range(5)) queue_byte(pick_byte(CHAR_NL));
    queue_byte(CHAR_NL);
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(12)) queue_byte(seq_letter());
      queue_byte(CHAR_NL);
    end
  endtask

  // One file: mostly well-formed records with random content, sometimes a
  // file with no record, a header cut by end of file, or random noise.
  task automatic queue_file();
    int unsigned style;
    int unsigned pick;
    style = $urandom_range(99);
    queue_item(CMD_NEW_FILE, 8'($urandom), 8'($urandom));
    if (style < 35) repeat ($urandom_range(4, 1)) queue_byte(pick_byte(CHAR_GT));
    if (style < 8) begin
      queue_item(CMD_EOF, 8'($urandom), 8'($urandom));
    end else begin
      repeat ($urandom_range(3, 1)) begin
        queue_record();
        if ($urandom_range(9) == 0) queue_load(8'($urandom), 8'($urandom));
      end
      if (style < 16) begin
        queue_byte(CHAR_GT);
        repeat ($urandom_range(3)) queue_byte(pick_byte(CHAR_NL));
      end else if (style < 24) begin
        repeat ($urandom_range(6, 1)) begin
          pick = $urandom_range(3);
          if (pick == 0) queue_load(8'($urandom), 8'($urandom));
          else if (pick == 1) queue_byte(8'($urandom));
          else if (pick == 2) queue_item(CMD_EOF, 8'($urandom), 8'($urandom));
          else queue_item(CMD_NEW_FILE, 8'($urandom), 8'($urandom));
        end
      end
      queue_item(CMD_EOF, 8'($urandom), 8'($urandom));
      // Bytes after the end are ignored while the parser is halted.
      if (style % 3 == 0) queue_byte(seq_letter());
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] term, logic [5:0] pads, logic [31:0] cap);
    write_reg(CFG_TERM_SYMBOL, {24'd0, term});
    write_reg(CFG_PAD_COUNT, {26'd0, pads});
    write_reg(CFG_BUFFER_LENGTH, cap);
    term_sh = term;
    pad_sh = pads;
    cap_sh = cap;
  endtask

  // Wait until every item is sent and every result has come back, then give
  // the block time to finish items that produce no result. The state is
  // looked at on the falling edge, once the sender's updates have settled.
  task automatic wait_idle();
    @(negedge clk_i);
    while (file_items.size() != 0 || in_valid_i || awaited_writes.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Gap length for either side: mostly none, some short, a few long, and now
  // and then a calm stretch with no gaps at all.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(999);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if (roll < 15) begin
      calm = $urandom_range(120, 30);
      return 0;
    end
    if (roll < 650) return 0;
    if (roll < 940) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  function automatic void flag_mismatch(string why, res_t exp_r, res_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t MISMATCH (%s): expected kind=%0d sym=%02h pos=%0d rec=%0d last=%0b",
               $time, why, exp_r.kind, exp_r.symbol, exp_r.position,
               exp_r.record_count, exp_r.last);
      $display("%0t              got kind=%0d sym=%02h pos=%0d rec=%0d last=%0b",
               $time, act_r.kind, act_r.symbol, act_r.position,
               act_r.record_count, act_r.last);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender. An accepted item runs through the packer at the edge that takes
  // it; a stalled item holds its payload until taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pack_step(cmd_e'(command_i), byte_value_i, table_value_i);
        send_gap = idle_len(send_calm);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (file_items.size() != 0) begin
          next_item = file_items.pop_front();
          in_valid_i <= 1'b1;
          command_i <= next_item.cmd;
          byte_value_i <= next_item.byte_value;
          table_value_i <= next_item.table_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. The stall pattern is random and independent of valid.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.kind = kind_e'(kind_o);
        got.symbol = symbol_o;
        got.position = position_o;
        got.record_count = record_count_o;
        got.last = last_o;
        if (awaited_writes.size() == 0) begin
          flag_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_writes.pop_front();
          if (got.kind !== want.kind || got.symbol !== want.symbol ||
              got.position !== want.position ||
              got.record_count !== want.record_count || got.last !== want.last)
            flag_mismatch("wrong field", want, got);
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap = idle_len(recv_calm);
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence: directed files first, then random phases, each under its
  // own register setting. Registers change only when the block is idle.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned roll;
    logic [5:0]  pads;
    logic [31:0] cap;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Table extremes, a dropping entry, status results and a two-record file.
    set_config(8'hA5, 6'd3, 32'hFFFF_FFFF);
    queue_load("A", 8'h7F);
    queue_load("N", 8'h80);
    queue_load("C", 8'h00);
    queue_item(CMD_EOF, 8'h00, 8'h00);          // no record at all
    queue_byte("A");                            // ignored while halted
    queue_item(CMD_NEW_FILE, 8'hFF, 8'hFF);
    queue_byte("x");
    queue_byte(CHAR_GT);
    queue_byte(8'h00);
    queue_item(CMD_EOF, 8'hFF, 8'h00);          // end inside the header
    queue_item(CMD_NEW_FILE, 8'h00, 8'h00);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_byte("A");
    queue_byte("N");
    queue_byte(8'hFF);
    queue_byte(CHAR_NL);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_byte("C");
    queue_item(CMD_EOF, 8'h00, 8'h00);
    wait_idle();

    // No padding: an empty file closes at length zero, and a '>' right
    // after the header line is an ordinary sequence byte.
    set_config(8'h00, 6'd0, 32'hFFFF_FFFF);
    queue_item(CMD_NEW_FILE, 8'h00, 8'h00);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_item(CMD_EOF, 8'h00, 8'h00);
    queue_item(CMD_NEW_FILE, 8'h00, 8'h00);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_byte(CHAR_GT);
    queue_byte("A");
    queue_item(CMD_EOF, 8'h00, 8'h00);
    wait_idle();

    // Longest padding bursts at every boundary.
    set_config(8'hFF, MAX_PAD, 32'hFFFF_FFFF);
    queue_item(CMD_NEW_FILE, 8'h00, 8'h00);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_byte("A");
    queue_byte(CHAR_NL);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_item(CMD_EOF, 8'h00, 8'h00);
    wait_idle();

    // The opening padding already passes the capacity; the first checked
    // symbol overflows and later items are ignored.
    set_config(8'h5A, 6'd5, 32'd3);
    queue_item(CMD_NEW_FILE, 8'h00, 8'h00);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    queue_byte("A");
    queue_byte("A");
    queue_item(CMD_EOF, 8'h00, 8'h00);
    wait_idle();

    // Overflow in the middle of a padding burst between records.
    set_config(8'hC3, 6'd4, 32'd10);
    queue_item(CMD_NEW_FILE, 8'h00, 8'h00);
    queue_byte(CHAR_GT);
    queue_byte(CHAR_NL);
    repeat (4) queue_byte("A");
    queue_byte(CHAR_NL);
    queue_byte(CHAR_GT);
    queue_item(CMD_EOF, 8'h00, 8'h00);
    wait_idle();

    // Random phases. Small capacities make overflow frequent; the largest
    // padding shows up only now and then.
    while (items_queued < ITEM_GOAL) begin
      roll = $urandom_range(99);
      if (roll < 15) pads = MAX_PAD;
      else if (roll < 30) pads = 6'd0;
      else pads = 6'($urandom_range(6, 1));
      roll = $urandom_range(99);
      if (roll < 40) cap = 32'hFFFF_FFFF;
      else if (roll < 60) cap = $urandom_range(12, 1);
      else cap = $urandom_range(120, 10);
      set_config(8'($urandom), pads, cap);
      repeat ($urandom_range(3, 1)) begin
        queue_file();
        // Sometimes the sender holds off until everything is back.
        if ($urandom_range(2) == 0) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && awaited_writes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/fsp_pkg.sv
rtl/core/fsp_ram.sv
rtl/core/fsp_engine.sv
rtl/core/fasta_symbol_stream_packer.sv
dv/tb.sv
